FILE: src/lrurs_pkg.sv
`default_nettype none

package lrurs_pkg;

  localparam int ID_W  = 16;
  localparam int MAX_W = 5;

  // op codes
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_PIN    = 2'd1;
  localparam logic [1:0] OP_UNPIN  = 2'd2;

  // register map (index taken from paddr[2])
  localparam logic REG_MAX_RESIDENT = 1'b0;

  localparam logic [MAX_W-1:0] MAX_RESIDENT_RST = 5'd4;
  localparam logic [MAX_W-1:0] MAX_RESIDENT_MIN = 5'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] item_id;
  } in_item_t;

  typedef struct packed {
    logic            was_resident;
    logic            evicted_valid;
    logic [ID_W-1:0] evicted_id;
    logic            overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: src/lrurs_ctrl.sv
`default_nettype none

module lrurs_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lrurs_pkg::ctl_sts_t sts,
  output lrurs_pkg::ctl_cmd_t cmd
);
  import lrurs_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.scan_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = sts.scan_busy;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/lrurs_datapath.sv
`default_nettype none

module lrurs_datapath #(
  parameter int STORE_DEPTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  lrurs_pkg::in_item_t              in_item,
  input  wire  [lrurs_pkg::MAX_W-1:0]      max_resident,
  input  wire                              out_ready,
  input  lrurs_pkg::ctl_cmd_t              cmd,
  output lrurs_pkg::ctl_sts_t              sts,
  output logic                             out_valid,
  output lrurs_pkg::out_item_t             out_item
);
  import lrurs_pkg::*;

  localparam int PW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (CW > MAX_W) ? CW : MAX_W;
  localparam logic [CW-1:0] FULL = CW'(STORE_DEPTH);

  // recency list, position 0 most recent
  logic [ID_W-1:0] ids_r   [STORE_DEPTH];
  logic [ID_W-1:0] ids_nxt [STORE_DEPTH];
  logic            flags_r   [STORE_DEPTH];
  logic            flags_nxt [STORE_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;

  // request being worked on
  logic [1:0]      op_r;
  logic [ID_W-1:0] id_r;
  logic [CW-1:0]   tries_r;
  logic            scan_r;
  logic            was_r;
  logic            ev_valid_r;
  logic [ID_W-1:0] ev_id_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [ID_W-1:0] key;
  logic            hit;
  logic [PW-1:0]   hit_pos;
  logic [CW-1:0]   last_cnt;
  logic [PW-1:0]   last_idx;
  logic [ID_W-1:0] last_id;
  logic            last_flag;
  logic            keep;
  logic            is_access;
  logic            is_pin;
  logic            evict;
  logic            insert;
  logic            ovf;
  logic            shift_en;
  logic [CW-1:0]   shift_bound;
  logic [ID_W-1:0] front_id;
  logic            front_flag;

  // lookup over the resident part of the list; lowest position wins
  assign key = cmd.load ? in_item.item_id : id_r;

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
      if ((CW'(i) < count_r) && (ids_r[i] == key)) begin
        hit     = 1'b1;
        hit_pos = PW'(i);
      end
    end
  end

  assign last_cnt  = count_r - CW'(1);
  assign last_idx  = last_cnt[PW-1:0];
  assign last_id   = ids_r[last_idx];
  assign last_flag = flags_r[last_idx];
  assign keep      = last_flag | (last_id == id_r);

  assign is_access = (op_r == OP_ACCESS);
  assign is_pin    = (op_r == OP_PIN) || (op_r == OP_UNPIN);
  assign evict     = cmd.step && !keep;
  assign insert    = cmd.finish && is_access && !hit && (count_r != FULL);
  assign ovf       = is_access && !hit && (count_r == FULL);

  always_comb begin
    shift_en    = 1'b0;
    shift_bound = last_cnt;
    front_id    = last_id;
    front_flag  = last_flag;
    priority if (cmd.step && keep) begin
      // rotate the least recent entry to the front
      shift_en = 1'b1;
    end else if (cmd.finish && is_access && hit) begin
      shift_en    = 1'b1;
      shift_bound = CW'(hit_pos);
      front_id    = id_r;
      front_flag  = flags_r[hit_pos];
    end else if (insert) begin
      shift_en    = 1'b1;
      shift_bound = count_r;
      front_id    = id_r;
      front_flag  = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      ids_nxt[i]   = ids_r[i];
      flags_nxt[i] = flags_r[i];
      if (shift_en) begin
        if (i == 0) begin
          ids_nxt[i]   = front_id;
          flags_nxt[i] = front_flag;
        end else if (CW'(i) <= shift_bound) begin
          ids_nxt[i]   = ids_r[i-1];
          flags_nxt[i] = flags_r[i-1];
        end
      end
    end
    if (cmd.finish && is_pin && hit) begin
      flags_nxt[hit_pos] = (op_r == OP_PIN);
    end
  end

  always_comb begin
    count_nxt = count_r;
    priority if (evict) begin
      count_nxt = last_cnt;
    end else if (insert) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      ids_r[i] <= ids_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        flags_r[i] <= 1'b0;
      end
      count_r     <= '0;
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        flags_r[i] <= flags_nxt[i];
      end
      count_r <= count_nxt;
      if (cmd.load) begin
        scan_r <= (in_item.op == OP_ACCESS) &&
                  (CMPW'(count_r) >= CMPW'(max_resident));
      end else if (evict) begin
        scan_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_item.op;
      id_r       <= in_item.item_id;
      tries_r    <= count_r;
      was_r      <= hit && ((in_item.op == OP_ACCESS) || (in_item.op == OP_PIN) ||
                            (in_item.op == OP_UNPIN));
      ev_valid_r <= 1'b0;
      ev_id_r    <= '0;
    end else if (cmd.step) begin
      if (keep) begin
        tries_r <= tries_r - CW'(1);
      end else begin
        ev_valid_r <= 1'b1;
        ev_id_r    <= last_id;
      end
    end
    if (cmd.finish) begin
      out_item_r.was_resident  <= was_r;
      out_item_r.evicted_valid <= ev_valid_r;
      out_item_r.evicted_id    <= ev_id_r;
      out_item_r.overflow      <= ovf;
    end
  end

  assign sts.scan_busy = scan_r && (tries_r != '0);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule

`default_nettype wire

FILE: src/lru_resident_set_with_pins_top.sv
`default_nettype none

// channel   ports                              direction  moves
// input     in_valid, in_ready, in_data        in         one request: op, item_id
// result    out_valid, out_ready, out_data     out        one result per request
// config    psel, penable, pwrite, paddr,      in/out     max_resident at address 0
//           pwdata, prdata, pready
//
// A request passes through the idle, scan and finish states; the eviction scan
// stops at the first evicted entry and looks at no more than resident_count
// entries, and runs only for an access when the set holds max_resident or more.
// Reset (rst_n low, synchronous) empties the set and sets max_resident to 4.
// The result register lets the next request be taken while a result waits;
// a request only completes once that register is free.

module lru_resident_set_with_pins_top #(
  parameter int STORE_DEPTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  lrurs_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output lrurs_pkg::out_item_t  out_data,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import lrurs_pkg::*;

  logic [MAX_W-1:0] max_r, max_nxt;
  logic             cfg_wr;
  ctl_cmd_t         cmd;
  ctl_sts_t         sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MAX_RESIDENT);
  assign max_nxt = (pwdata[MAX_W-1:0] < MAX_RESIDENT_MIN) ? MAX_RESIDENT_MIN
                                                          : pwdata[MAX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_RESIDENT_RST;
    end else if (cfg_wr) begin
      max_r <= max_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_MAX_RESIDENT) ? {{(32-MAX_W){1'b0}}, max_r} : '0;

  lrurs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrurs_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_data),
    .max_resident (max_r),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_item     (out_data)
  );

endmodule

`default_nettype wire
